[design/ray_box_slab_test_unit_defines.svh]
// assertion macros for the ray box slab test unit
`ifndef RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RBS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBS_ASSERT(label, clk, rst_n, prop, msg)
`define RBS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[design/rbs_pkg.sv]
// shared constants for the ray box slab test unit
package rbs_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_AXES       = 3;
endpackage

[design/ray_box_slab_test_unit.sv]
// start to o_result_valid (Q16.16 by default): axis input regs, divider stages, merge stage 1, output regs
// throughput: one box test per cycle; busy stays low, each divider is a bit-per-stage pipe
// the two pipelined dividers per axis set the latency, one stage per quotient bit
// reset (synchronous, i_rst_n low) clears all valid bits; payload is not reset
// results appear for one cycle on o_result_valid and cannot be stalled
module ray_box_slab_test_unit #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_box_low_x,
    input  logic signed [COORD_BITS-1:0] i_box_low_y,
    input  logic signed [COORD_BITS-1:0] i_box_low_z,
    input  logic signed [COORD_BITS-1:0] i_box_high_x,
    input  logic signed [COORD_BITS-1:0] i_box_high_y,
    input  logic signed [COORD_BITS-1:0] i_box_high_z,
    input  logic signed [COORD_BITS-1:0] i_ray_origin_x,
    input  logic signed [COORD_BITS-1:0] i_ray_origin_y,
    input  logic signed [COORD_BITS-1:0] i_ray_origin_z,
    input  logic signed [COORD_BITS-1:0] i_ray_dir_x,
    input  logic signed [COORD_BITS-1:0] i_ray_dir_y,
    input  logic signed [COORD_BITS-1:0] i_ray_dir_z,
    output logic                         o_result_valid,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_t_near,
    output logic signed [COORD_BITS-1:0] o_t_far
);
    import rbs_pkg::*;
    `include "ray_box_slab_test_unit_defines.svh"

    logic n_in;
    assign busy = 1'b0;
    assign n_in = start && !busy;

    logic [NUM_AXES-1:0]          n_v, n_ok;
    logic signed [COORD_BITS-1:0] n_tn [NUM_AXES];
    logic signed [COORD_BITS-1:0] n_tf [NUM_AXES];

    rbs_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ax_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(n_in),
        .i_lo(i_box_low_x), .i_hi(i_box_high_x), .i_org(i_ray_origin_x),
        .i_dir(i_ray_dir_x), .o_valid(n_v[0]), .o_ok(n_ok[0]),
        .o_tn(n_tn[0]), .o_tf(n_tf[0]));
    rbs_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ax_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(n_in),
        .i_lo(i_box_low_y), .i_hi(i_box_high_y), .i_org(i_ray_origin_y),
        .i_dir(i_ray_dir_y), .o_valid(n_v[1]), .o_ok(n_ok[1]),
        .o_tn(n_tn[1]), .o_tf(n_tf[1]));
    rbs_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ax_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(n_in),
        .i_lo(i_box_low_z), .i_hi(i_box_high_z), .i_org(i_ray_origin_z),
        .i_dir(i_ray_dir_z), .o_valid(n_v[2]), .o_ok(n_ok[2]),
        .o_tn(n_tn[2]), .o_tf(n_tf[2]));

    // merge stage 1: x against y
    logic                         r_m_v, r_m_ok;
    logic signed [COORD_BITS-1:0] r_m_tn, r_m_tf, r_m_tnz, r_m_tfz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= n_v[0];
        end
        r_m_ok  <= &n_ok;
        r_m_tn  <= (n_tn[0] > n_tn[1]) ? n_tn[0] : n_tn[1];
        r_m_tf  <= (n_tf[0] < n_tf[1]) ? n_tf[0] : n_tf[1];
        r_m_tnz <= n_tn[2];
        r_m_tfz <= n_tf[2];
    end

    // merge stage 2: fold z, check overlap
    logic signed [COORD_BITS-1:0] n_near, n_far;
    logic                         n_hit;
    assign n_near = (r_m_tnz > r_m_tn) ? r_m_tnz : r_m_tn;
    assign n_far  = (r_m_tfz < r_m_tf) ? r_m_tfz : r_m_tf;
    assign n_hit  = r_m_ok && !(n_near > n_far);

    logic                         r_o_v, r_o_hit;
    logic signed [COORD_BITS-1:0] r_o_tn, r_o_tf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_m_v;
        end
        r_o_hit <= n_hit;
        r_o_tn  <= n_hit ? n_near : '0;
        r_o_tf  <= n_hit ? n_far : '0;
    end

    assign o_result_valid = r_o_v;
    assign o_hit          = r_o_hit;
    assign o_t_near       = r_o_tn;
    assign o_t_far        = r_o_tf;

    `RBS_ASSERT(a_axes_aligned, i_clk, i_rst_n, (n_v[0] == n_v[1]) && (n_v[1] == n_v[2]), "axis valids out of step")
    `RBS_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_result_valid && !o_hit) |-> (o_t_near == '0 && o_t_far == '0), "miss with nonzero distances")
    `RBS_ASSERT(a_hit_order, i_clk, i_rst_n, (o_result_valid && o_hit) |-> !(o_t_near > o_t_far), "hit with near past far")
    `RBS_ASSERT(a_merge_flow, i_clk, i_rst_n, r_m_v |=> o_result_valid, "merge result lost")
endmodule

[design/rbs_divider.sv]
// pipelined restoring divider: one quotient bit per stage, saturating
module rbs_divider #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS:0]   i_num,
    input  logic signed [COORD_BITS-1:0] i_den,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_quot
);
    import rbs_pkg::*;
    `include "ray_box_slab_test_unit_defines.svh"

    // numerator magnitude is COORD_BITS+1 wide, shifted by FRAC_BITS
    localparam int NW = COORD_BITS + 1 + FRAC_BITS;
    localparam int DW = COORD_BITS;
    localparam int ST = NW;
    localparam logic [NW-1:0] LIM_POS = NW'((64'd1 << (COORD_BITS-1)) - 64'd1);
    localparam logic [NW-1:0] LIM_NEG = NW'(64'd1 << (COORD_BITS-1));

    logic [ST:0]         r_v;
    logic [NW-1:0]       r_n   [ST+1];
    logic [NW-1:0]       r_q   [ST+1];
    logic [DW:0]         r_rem [ST+1];
    logic [DW-1:0]       r_d   [ST+1];
    logic                r_neg [ST+1];

    logic [COORD_BITS:0]   n_nmag;
    logic [COORD_BITS-1:0] n_dmag;
    assign n_nmag = i_num[COORD_BITS] ? (COORD_BITS+1)'(-i_num) : i_num;
    assign n_dmag = i_den[COORD_BITS-1] ? COORD_BITS'(-i_den) : i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[ST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_n[0]   <= {n_nmag, {FRAC_BITS{1'b0}}};
        r_q[0]   <= '0;
        r_rem[0] <= '0;
        r_d[0]   <= n_dmag;
        r_neg[0] <= i_num[COORD_BITS] ^ i_den[COORD_BITS-1];
    end

    for (genvar s = 0; s < ST; s++) begin : g_stage
        logic [DW+1:0] n_trial;
        logic [DW+1:0] n_sh;
        assign n_sh    = {r_rem[s], r_n[s][NW-1]};
        assign n_trial = n_sh - {2'b00, r_d[s]};
        always_ff @(posedge i_clk) begin
            r_n[s+1]   <= {r_n[s][NW-2:0], 1'b0};
            r_d[s+1]   <= r_d[s];
            r_neg[s+1] <= r_neg[s];
            if (!n_trial[DW+1]) begin
                r_rem[s+1] <= n_trial[DW:0];
                r_q[s+1]   <= {r_q[s][NW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_sh[DW:0];
                r_q[s+1]   <= {r_q[s][NW-2:0], 1'b0};
            end
        end
    end

    logic [NW-1:0] n_lim;
    logic [NW-1:0] n_qs;
    assign n_lim = r_neg[ST] ? LIM_NEG : LIM_POS;
    assign n_qs  = (r_q[ST] > n_lim) ? n_lim : r_q[ST];

    logic                         r_ov;
    logic signed [COORD_BITS-1:0] r_oq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[ST];
        end
        r_oq <= r_neg[ST] ? COORD_BITS'(-n_qs) : n_qs[COORD_BITS-1:0];
    end
    assign o_valid = r_ov;
    assign o_quot  = r_oq;

    `RBS_ASSERT(a_div_lat, i_clk, i_rst_n, r_v[ST] |=> r_ov, "divider valid lost")
    `RBS_ASSERT(a_div_in, i_clk, i_rst_n, i_valid |=> r_v[0], "divider entry lost")
    `RBS_ASSERT(a_div_none, i_clk, i_rst_n, !r_v[ST] |=> !r_ov, "divider valid invented")
endmodule

[design/rbs_axis.sv]
// one axis of the slab test: differences, two divides, ordering by sign
module rbs_axis #(
    parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_lo,
    input  logic signed [COORD_BITS-1:0] i_hi,
    input  logic signed [COORD_BITS-1:0] i_org,
    input  logic signed [COORD_BITS-1:0] i_dir,
    output logic                         o_valid,
    output logic                         o_ok,
    output logic signed [COORD_BITS-1:0] o_tn,
    output logic signed [COORD_BITS-1:0] o_tf
);
    import rbs_pkg::*;

    localparam int LAT = COORD_BITS + 1 + FRAC_BITS + 2;
    localparam logic signed [COORD_BITS-1:0] TMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] TMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                         r_v;
    logic signed [COORD_BITS:0]   r_dlo, r_dhi;
    logic signed [COORD_BITS-1:0] r_dir;
    logic                         r_inside;
    logic                         r_zero, r_negd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
        r_dlo    <= (COORD_BITS+1)'(i_lo) - (COORD_BITS+1)'(i_org);
        r_dhi    <= (COORD_BITS+1)'(i_hi) - (COORD_BITS+1)'(i_org);
        r_dir    <= i_dir;
        r_inside <= !(i_org < i_lo) && !(i_org > i_hi);
        r_zero   <= (i_dir == '0);
        r_negd   <= i_dir[COORD_BITS-1];
    end

    logic                         n_v0, n_v1;
    logic signed [COORD_BITS-1:0] n_q0, n_q1;
    rbs_divider #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_lo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v),
        .i_num(r_dlo), .i_den(r_dir), .o_valid(n_v0), .o_quot(n_q0));
    rbs_divider #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_hi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v),
        .i_num(r_dhi), .i_den(r_dir), .o_valid(n_v1), .o_quot(n_q1));

    // side flags ride alongside the dividers
    logic [LAT-1:0] r_z_d, r_n_d, r_i_d;
    always_ff @(posedge i_clk) begin
        r_z_d <= {r_z_d[LAT-2:0], r_zero};
        r_n_d <= {r_n_d[LAT-2:0], r_negd};
        r_i_d <= {r_i_d[LAT-2:0], r_inside};
    end

    logic zf, nf, inf;
    assign zf  = r_z_d[LAT-1];
    assign nf  = r_n_d[LAT-1];
    assign inf = r_i_d[LAT-1];

    assign o_valid = n_v0 && n_v1;
    assign o_ok    = !zf || inf;
    assign o_tn    = zf ? TMIN : (nf ? n_q1 : n_q0);
    assign o_tf    = zf ? TMAX : (nf ? n_q0 : n_q1);
endmodule
